FILE: sv/rdq_pkg.sv
// ============================================================================
// rdq_pkg
// Shared widths, operation codes and status codes of the reversible deque.
// ============================================================================
package rdq_pkg;

  localparam int unsigned DEPTH_DEF = 1024;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned STATUS_W  = 2;

  typedef logic [KIND_W-1:0]          kind_t;
  typedef logic signed [WORD_W-1:0]   word_t;
  typedef logic [STATUS_W-1:0]        status_t;

  localparam kind_t KIND_PUSH_FRONT = 3'd0;
  localparam kind_t KIND_PUSH_BACK  = 3'd1;
  localparam kind_t KIND_POP_FRONT  = 3'd2;
  localparam kind_t KIND_POP_BACK   = 3'd3;
  localparam kind_t KIND_REVERSE    = 3'd4;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  function automatic int unsigned cnt_width(int unsigned depth);
    return $clog2(depth + 1);
  endfunction

endpackage

FILE: sv/rdq_if.sv
// ============================================================================
// rdq_if
// Request and result channels of the reversible deque, valid/ready handshake.
// ============================================================================
interface rdq_in_if
  import rdq_pkg::*;
;
  logic  valid;
  logic  ready;
  kind_t kind;
  word_t push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface rdq_out_if
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
);
  localparam int unsigned CNT_W = cnt_width(DEPTH);

  logic             valid;
  logic             ready;
  word_t            front_value;
  word_t            back_value;
  logic [CNT_W-1:0] entry_count;
  logic             is_empty;
  status_t          status;

  modport source (output valid, output front_value, output back_value,
                  output entry_count, output is_empty, output status, input ready);
  modport sink   (input valid, input front_value, input back_value,
                  input entry_count, input is_empty, input status, output ready);
endinterface

FILE: sv/reversible_deque.sv
// ============================================================================
// reversible_deque
// Double-ended queue of signed words in a circular ring, with a reverse that
// only swaps which physical end is the logical front.
// ============================================================================
// Each request on in_ch is one operation: push front, push back, pop front,
// pop back or reverse. Every request gives exactly one result on out_ch with
// the logical front and back words, the count, an empty flag and a status.
// A push into a full deque or a pop from an empty one changes nothing and is
// reported in the status. Unused operation codes report the current state.
// The pointers and count are updated when the request is taken; the ring
// memory is read at the new ends at that same edge into the read stage, and
// the result then passes to the output register, which drives out_ch.
// One request is taken every cycle unless out_ch stalls, with a single
// registered read of the two ring ports.
// After reset the deque is empty and not reversed; the ring is not cleared,
// since only written words are ever read. If out_ch stalls, one result waits
// in the output register and one in the read stage; in_ch.ready then drops
// until the receiver takes a result.
// ============================================================================
module reversible_deque
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rdq_in_if.sink     in_ch,
  rdq_out_if.source  out_ch
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = cnt_width(DEPTH);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

  logic [PTR_W-1:0] low_r, low_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rev_r, rev_nxt;

  logic             acc;
  logic             in_ready;
  logic             at_low;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] low_dec, low_inc;
  logic [SUM_W-1:0] tail_sum, hi_sum;
  logic [PTR_W-1:0] tail_addr, rd_hi_addr;
  status_t          status_nxt;

  word_t            ring_mem [DEPTH];
  word_t            rd_lo_r, rd_hi_r;

  logic             b_v_r;
  logic             b_go;
  logic [CNT_W-1:0] b_cnt_r;
  logic             b_rev_r;
  status_t          b_status_r;
  logic             b_byp_lo_r, b_byp_hi_r;
  word_t            b_val_r;
  word_t            lo_word, hi_word;

  logic             out_v_r;
  word_t            out_front_r, out_back_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_empty_r;
  status_t          out_status_r;

  assign acc      = in_ch.valid & in_ready;
  assign b_go     = b_v_r & (~out_v_r | out_ch.ready);
  assign in_ready = ~b_v_r | b_go;
  assign in_ch.ready = in_ready;

  assign at_low  = ((in_ch.kind == KIND_PUSH_FRONT) || (in_ch.kind == KIND_POP_FRONT)) != rev_r;
  assign low_dec = (low_r == '0) ? LAST_P : low_r - PTR_W'(1);
  assign low_inc = (low_r == LAST_P) ? '0 : low_r + PTR_W'(1);

  assign tail_sum  = SUM_W'(low_r) + SUM_W'(cnt_r);
  assign tail_addr = PTR_W'((tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum);

  always_comb begin
    low_nxt    = low_r;
    cnt_nxt    = cnt_r;
    rev_nxt    = rev_r;
    wr_en      = 1'b0;
    wr_addr    = tail_addr;
    status_nxt = ST_DONE;
    unique case (in_ch.kind) inside
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (cnt_r == DEPTH_C) begin
          status_nxt = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          wr_en   = 1'b1;
          if (at_low) begin
            low_nxt = low_dec;
            wr_addr = low_dec;
          end
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (cnt_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
          if (at_low) begin
            low_nxt = low_inc;
          end
        end
      end
      KIND_REVERSE: begin
        rev_nxt = ~rev_r;
      end
      default: begin
      end
    endcase
  end

  assign hi_sum     = SUM_W'(low_nxt) + SUM_W'(cnt_nxt) - SUM_W'(1);
  assign rd_hi_addr = (cnt_nxt == '0) ? low_nxt :
                      PTR_W'((hi_sum >= DEPTH_S) ? hi_sum - DEPTH_S : hi_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r <= '0;
      cnt_r <= '0;
      rev_r <= 1'b0;
    end else if (acc) begin
      low_r <= low_nxt;
      cnt_r <= cnt_nxt;
      rev_r <= rev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && wr_en) begin
      ring_mem[wr_addr] <= in_ch.push_value;
    end
    if (acc) begin
      rd_lo_r <= ring_mem[low_nxt];
      rd_hi_r <= ring_mem[rd_hi_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (acc) begin
      b_v_r <= 1'b1;
    end else if (b_go) begin
      b_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_cnt_r    <= cnt_nxt;
      b_rev_r    <= rev_nxt;
      b_status_r <= status_nxt;
      b_byp_lo_r <= wr_en && (wr_addr == low_nxt);
      b_byp_hi_r <= wr_en && (wr_addr == rd_hi_addr);
      b_val_r    <= in_ch.push_value;
    end
  end

  always_comb begin
    lo_word = b_byp_lo_r ? b_val_r : rd_lo_r;
    hi_word = b_byp_hi_r ? b_val_r : rd_hi_r;
    if (b_cnt_r == '0) begin
      lo_word = '0;
      hi_word = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (b_go) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      out_front_r  <= b_rev_r ? hi_word : lo_word;
      out_back_r   <= b_rev_r ? lo_word : hi_word;
      out_cnt_r    <= b_cnt_r;
      out_empty_r  <= (b_cnt_r == '0);
      out_status_r <= b_status_r;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.front_value = out_front_r;
  assign out_ch.back_value  = out_back_r;
  assign out_ch.entry_count = out_cnt_r;
  assign out_ch.is_empty    = out_empty_r;
  assign out_ch.status      = out_status_r;

endmodule

FILE: sv/rdq_checker.sv
// ============================================================================
// rdq_checker
// Port-level checks of the reversible deque results, bound to the top level.
// ============================================================================
module rdq_checker
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input word_t                        out_front_value,
  input word_t                        out_back_value,
  input logic [cnt_width(DEPTH)-1:0]  out_entry_count,
  input logic                         out_is_empty,
  input status_t                      out_status
);

  localparam int unsigned CNT_W = cnt_width(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result withdrawn before it was taken.");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0)))
    else $error("Empty flag disagrees with the count.");

  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> (out_front_value == '0) && (out_back_value == '0))
    else $error("Empty deque reports non-zero end words.");

  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_entry_count == DEPTH_C))
    else $error("Push refused while the deque was not full.");

  a_empty_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> out_is_empty)
    else $error("Pop refused while the deque held words.");

endmodule

bind reversible_deque rdq_checker #(.DEPTH(DEPTH)) u_rdq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_front_value (out_ch.front_value),
  .out_back_value  (out_ch.back_value),
  .out_entry_count (out_ch.entry_count),
  .out_is_empty    (out_ch.is_empty),
  .out_status      (out_ch.status)
);
